/* design/rsi_pkg.sv */
// rsi_pkg: shared widths, item types and the quarter-wave sine table
// for the ray versus segment intersection block; no dependencies
`default_nettype none

package rsi_pkg;

    localparam int ANGLE_W    = 12;
    localparam int ANGLE_BITS = 12;
    localparam int QTR_BITS   = ANGLE_BITS - 2;
    localparam int QTR        = 1 << QTR_BITS;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int TRIG_W     = 16;
    localparam int MAG_TRIG_W = TRIG_W - 1;
    localparam int PROD_W     = TRIG_W + DIFF_W;
    localparam int DEN_W      = PROD_W + 1;
    localparam int MAG_DEN_W  = DEN_W - 1;
    localparam int CROSS_W    = 2 * DIFF_W;
    localparam int NT_W       = CROSS_W + 1;
    localparam int MAG_NT_W   = NT_W - 1;
    localparam int NUM_W      = MAG_NT_W + MAG_TRIG_W;
    localparam int QUO_W      = 35;
    localparam int SUM_W      = QUO_W + 3;

    localparam logic [63:0] PI_HALF_Q61 = 64'h3243F6A8885A308D;

    typedef logic [MAG_TRIG_W-1:0] t_sin_rom [0:QTR];

    typedef struct packed {
        logic signed [COORD_W-1:0] wall_ax;
        logic signed [COORD_W-1:0] wall_ay;
        logic signed [COORD_W-1:0] wall_bx;
        logic signed [COORD_W-1:0] wall_by;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic        [ANGLE_W-1:0] ray_angle;
    } t_ray;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic                      clipped;
    } t_hit;

    typedef struct packed {
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic                      neg_x;
        logic                      neg_y;
        logic                      hit;
    } t_div_side;

    typedef struct packed {
        logic [MAG_DEN_W-1:0] rem_x;
        logic [MAG_DEN_W-1:0] rem_y;
        logic [QUO_W-1:0]     quo_x;
        logic [QUO_W-1:0]     quo_y;
        logic [MAG_DEN_W-1:0] den;
        t_div_side            side;
    } t_div_res;

    // unsigned q3.61 product
    function automatic logic [63:0] mulq61(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // round(32767*sin(pi/2*i/QTR)) by taylor series, elaboration only
    function automatic logic [MAG_TRIG_W-1:0] quarter_sin(int unsigned i);
        logic [63:0] ix;
        logic [63:0] theta;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] acc;
        ix    = 64'(i);
        theta = (PI_HALF_Q61 >> QTR_BITS) * ix
              + (((PI_HALF_Q61 & ((64'd1 << QTR_BITS) - 64'd1)) * ix) >> QTR_BITS);
        th2   = mulq61(theta, theta);
        term  = theta;
        sum   = theta;
        for (int n = 1; n < 29; n += 2) begin
            term = mulq61(term, th2) / 64'((n + 1) * (n + 2));
            if (((n >> 1) & 1) == 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        acc = 64'd32767 * (sum >> 32) + ((64'd32767 * (sum & 64'hFFFF_FFFF)) >> 32);
        return MAG_TRIG_W'((acc + (64'd1 << 28)) >> 29);
    endfunction

    function automatic t_sin_rom build_sin_rom();
        t_sin_rom r;
        for (int i = 0; i <= QTR; i++) begin
            r[i] = quarter_sin(i);
        end
        return r;
    endfunction

    localparam t_sin_rom SIN_ROM = build_sin_rom();

endpackage

`default_nettype wire

/* design/rsi_ifaces.sv */
// rsi_ifaces: valid/ready channel interfaces for ray items and hit results
// depends on rsi_pkg
`default_nettype none

interface rsi_ray_if;
    logic          valid;
    logic          ready;
    rsi_pkg::t_ray data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rsi_hit_if;
    logic          valid;
    logic          ready;
    rsi_pkg::t_hit data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/rsi_divider.sv */
// rsi_divider: pipelined restoring divider, one quotient bit per stage,
// two numerators over one shared denominator; depends on rsi_pkg
`default_nettype none

module rsi_divider (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  [rsi_pkg::NUM_W-1:0]        i_num_x,
    input  wire  [rsi_pkg::NUM_W-1:0]        i_num_y,
    input  wire  [rsi_pkg::MAG_DEN_W-1:0]    i_den,
    input  wire  rsi_pkg::t_div_side         i_side,
    output logic                             o_valid,
    input  wire                              i_ready,
    output rsi_pkg::t_div_res                o_res
);

    localparam int QW = rsi_pkg::QUO_W;
    localparam int DW = rsi_pkg::MAG_DEN_W;

    typedef struct packed {
        logic [DW-1:0]       rem_x;
        logic [DW-1:0]       rem_y;
        logic [QW-1:0]       low_x;
        logic [QW-1:0]       low_y;
        logic [QW-1:0]       quo_x;
        logic [QW-1:0]       quo_y;
        logic [DW-1:0]       den;
        rsi_pkg::t_div_side  side;
    } t_stage;

    t_stage        r_st [QW];
    t_stage        n_st [QW];
    t_stage        first;
    logic [QW-1:0] r_v;
    logic [QW:0]   rdy;

    function automatic t_stage step(t_stage a);
        logic [DW:0] tx;
        logic [DW:0] ty;
        t_stage      r;
        r       = a;
        tx      = {a.rem_x, a.low_x[QW-1]};
        ty      = {a.rem_y, a.low_y[QW-1]};
        r.low_x = a.low_x << 1;
        r.low_y = a.low_y << 1;
        if (tx >= {1'b0, a.den}) begin
            tx      = tx - {1'b0, a.den};
            r.quo_x = {a.quo_x[QW-2:0], 1'b1};
        end else begin
            r.quo_x = {a.quo_x[QW-2:0], 1'b0};
        end
        if (ty >= {1'b0, a.den}) begin
            ty      = ty - {1'b0, a.den};
            r.quo_y = {a.quo_y[QW-2:0], 1'b1};
        end else begin
            r.quo_y = {a.quo_y[QW-2:0], 1'b0};
        end
        r.rem_x = tx[DW-1:0];
        r.rem_y = ty[DW-1:0];
        return r;
    endfunction

    always_comb begin
        first.rem_x = DW'(i_num_x[rsi_pkg::NUM_W-1:QW]);
        first.rem_y = DW'(i_num_y[rsi_pkg::NUM_W-1:QW]);
        first.low_x = i_num_x[QW-1:0];
        first.low_y = i_num_y[QW-1:0];
        first.quo_x = '0;
        first.quo_y = '0;
        first.den   = i_den;
        first.side  = i_side;
        n_st[0]     = step(first);
        for (int j = 1; j < QW; j++) begin
            n_st[j] = step(r_st[j-1]);
        end
    end

    always_comb begin
        rdy[QW] = i_ready;
        for (int j = QW - 1; j >= 0; j--) begin
            rdy[j] = !r_v[j] || rdy[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < QW; j++) begin
                if (rdy[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QW; j++) begin
            if (rdy[j]) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[QW-1];
    assign o_res   = {r_st[QW-1].rem_x, r_st[QW-1].rem_y, r_st[QW-1].quo_x,
                      r_st[QW-1].quo_y, r_st[QW-1].den, r_st[QW-1].side};

endmodule

`default_nettype wire

/* design/ray_segment_intersect_top.sv */
// ray_segment_intersect_top: 2d ray versus wall segment intersection
// depends on rsi_pkg, rsi_ifaces and rsi_divider
//
// usage:
//   i_ray carries one ray/wall transaction: wall endpoints a and b, ray
//   origin (all signed q16.16) and a ray angle in 4096 steps per turn.
//   o_hit returns exactly one transaction per input, in order: hit flag,
//   hit point (q16.16, zero on a miss) and a saturation flag.
//   the path from acceptance to o_hit.valid runs through five arithmetic
//   stages (sine rom lookup, cross products, differences, range tests,
//   scaling), 35 stages of the restoring divider that forms t*d at one
//   quotient bit per stage, and the rounding/output register.
//   throughput is one transaction per cycle while o_hit.ready is high; every stage holds a valid bit.
//   when o_hit.ready is low the result is held and stages behind it keep
//   filling empty slots; i_ray.ready falls only once the pipe is full.
//   synchronous reset clears all valid bits; no result is pending after it.
`default_nettype none

module ray_segment_intersect_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rsi_ray_if.sink    i_ray,
    rsi_hit_if.source  o_hit
);

    localparam int CW  = rsi_pkg::COORD_W;
    localparam int XW  = rsi_pkg::DIFF_W;
    localparam int TW  = rsi_pkg::TRIG_W;
    localparam int MTW = rsi_pkg::MAG_TRIG_W;
    localparam int PW  = rsi_pkg::PROD_W;
    localparam int DNW = rsi_pkg::DEN_W;
    localparam int MDW = rsi_pkg::MAG_DEN_W;
    localparam int CRW = rsi_pkg::CROSS_W;
    localparam int NTW = rsi_pkg::NT_W;
    localparam int MNW = rsi_pkg::MAG_NT_W;
    localparam int NMW = rsi_pkg::NUM_W;
    localparam int SW  = rsi_pkg::SUM_W;
    localparam int QB  = rsi_pkg::QTR_BITS;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    // stage 0: differences and sine lookup
    logic                  r_v0;
    logic signed [XW-1:0]  r_wx, r_wy, r_ex, r_ey;
    logic signed [CW-1:0]  r_ox0, r_oy0;
    logic [1:0]            r_quad;
    logic [MTW-1:0]        r_sq, r_cq;
    logic [QB-1:0]         ang_q;
    logic [QB:0]           idx_c;

    // stage 1: cross products
    logic                  r_v1;
    logic signed [PW-1:0]  r_pd1, r_pd2, r_pu1, r_pu2;
    logic signed [CRW-1:0] r_pn1, r_pn2;
    logic [MTW-1:0]        r_cm, r_sm;
    logic                  r_cneg, r_sneg;
    logic signed [CW-1:0]  r_ox1, r_oy1;
    logic                  c_neg, s_neg;
    logic [MTW-1:0]        c_mag, s_mag;
    logic signed [TW-1:0]  c_val, s_val;

    // stage 2: den, nt, nu
    logic                  r_v2;
    logic signed [DNW-1:0] r_den, r_nu;
    logic signed [NTW-1:0] r_nt;
    logic [MTW-1:0]        r_cm2, r_sm2;
    logic                  r_cneg2, r_sneg2;
    logic signed [CW-1:0]  r_ox2, r_oy2;

    // stage 3: range tests and magnitudes
    logic                  r_v3;
    logic [MNW-1:0]        r_mnt;
    logic [MDW-1:0]        r_mden;
    logic [MTW-1:0]        r_cm3, r_sm3;
    rsi_pkg::t_div_side    r_side3;
    logic                  den_neg, nt_neg, nu_neg, t_ok, u_ok;
    logic [MDW-1:0]        mag_nu, mag_den;

    // stage 4: scaled numerators
    logic                  r_v4;
    logic [NMW-1:0]        r_numx, r_numy;
    logic [MDW-1:0]        r_mden4;
    rsi_pkg::t_div_side    r_side4;

    // divider and output
    logic                  div_ready, div_valid;
    rsi_pkg::t_div_res     div_res;
    logic                  r_v5;
    rsi_pkg::t_hit         r_out;
    rsi_pkg::t_hit         n_out;
    logic                  rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;
    logic                  rnd_x, rnd_y;
    logic signed [SW-1:0]  q_x, q_y, sum_x, sum_y;

    assign rdy5 = !r_v5 || o_hit.ready;
    assign rdy4 = !r_v4 || div_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign i_ray.ready = rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_ray.valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= div_valid;
            end
        end
    end

    // stage 0
    assign ang_q = i_ray.data.ray_angle[QB-1:0];
    assign idx_c = (QB+1)'(rsi_pkg::QTR) - {1'b0, ang_q};

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_wx   <= XW'(i_ray.data.wall_bx) - XW'(i_ray.data.wall_ax);
            r_wy   <= XW'(i_ray.data.wall_by) - XW'(i_ray.data.wall_ay);
            r_ex   <= XW'(i_ray.data.wall_ax) - XW'(i_ray.data.origin_x);
            r_ey   <= XW'(i_ray.data.wall_ay) - XW'(i_ray.data.origin_y);
            r_ox0  <= i_ray.data.origin_x;
            r_oy0  <= i_ray.data.origin_y;
            r_quad <= i_ray.data.ray_angle[rsi_pkg::ANGLE_BITS-1 -: 2];
            r_sq   <= rsi_pkg::SIN_ROM[{1'b0, ang_q}];
            r_cq   <= rsi_pkg::SIN_ROM[idx_c];
        end
    end

    // stage 1: quadrant symmetry, then products
    always_comb begin
        c_mag = r_quad[0] ? r_sq : r_cq;
        s_mag = r_quad[0] ? r_cq : r_sq;
        c_neg = r_quad[1] ^ r_quad[0];
        s_neg = r_quad[1];
        c_val = c_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
        s_val = s_neg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_pd1  <= c_val * r_wy;
            r_pd2  <= s_val * r_wx;
            r_pn1  <= r_ex * r_wy;
            r_pn2  <= r_ey * r_wx;
            r_pu1  <= r_ex * s_val;
            r_pu2  <= r_ey * c_val;
            r_cm   <= c_mag;
            r_sm   <= s_mag;
            r_cneg <= c_neg;
            r_sneg <= s_neg;
            r_ox1  <= r_ox0;
            r_oy1  <= r_oy0;
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_den   <= DNW'(r_pd1) - DNW'(r_pd2);
            r_nt    <= NTW'(r_pn1) - NTW'(r_pn2);
            r_nu    <= DNW'(r_pu1) - DNW'(r_pu2);
            r_cm2   <= r_cm;
            r_sm2   <= r_sm;
            r_cneg2 <= r_cneg;
            r_sneg2 <= r_sneg;
            r_ox2   <= r_ox1;
            r_oy2   <= r_oy1;
        end
    end

    // stage 3: t >= 0 and 0 <= u <= 1 by signs and magnitudes
    always_comb begin
        den_neg = r_den[DNW-1];
        nt_neg  = r_nt[NTW-1];
        nu_neg  = r_nu[DNW-1];
        mag_den = den_neg ? MDW'(-r_den) : MDW'(r_den);
        mag_nu  = nu_neg ? MDW'(-r_nu) : MDW'(r_nu);
        t_ok    = (r_nt == '0) || (nt_neg == den_neg);
        u_ok    = (r_nu == '0) || ((nu_neg == den_neg) && (mag_nu <= mag_den));
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_mnt          <= nt_neg ? MNW'(-r_nt) : MNW'(r_nt);
            r_mden         <= mag_den;
            r_cm3          <= r_cm2;
            r_sm3          <= r_sm2;
            r_side3.base_x <= r_ox2;
            r_side3.base_y <= r_oy2;
            r_side3.neg_x  <= nt_neg ^ r_cneg2 ^ den_neg;
            r_side3.neg_y  <= nt_neg ^ r_sneg2 ^ den_neg;
            r_side3.hit    <= (r_den != '0) && t_ok && u_ok;
        end
    end

    // stage 4
    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_numx  <= NMW'(r_mnt) * NMW'(r_cm3);
            r_numy  <= NMW'(r_mnt) * NMW'(r_sm3);
            r_mden4 <= r_mden;
            r_side4 <= r_side3;
        end
    end

    rsi_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .o_ready (div_ready),
        .i_num_x (r_numx),
        .i_num_y (r_numy),
        .i_den   (r_mden4),
        .i_side  (r_side4),
        .o_valid (div_valid),
        .i_ready (rdy5),
        .o_res   (div_res)
    );

    // round to nearest, offset by origin, saturate
    always_comb begin
        rnd_x = {div_res.rem_x, 1'b0} >= {1'b0, div_res.den};
        rnd_y = {div_res.rem_y, 1'b0} >= {1'b0, div_res.den};
        q_x   = SW'(div_res.quo_x) + SW'(rnd_x);
        q_y   = SW'(div_res.quo_y) + SW'(rnd_y);
        sum_x = div_res.side.neg_x ? SW'(div_res.side.base_x) - q_x
                                   : SW'(div_res.side.base_x) + q_x;
        sum_y = div_res.side.neg_y ? SW'(div_res.side.base_y) - q_y
                                   : SW'(div_res.side.base_y) + q_y;
        n_out = '0;
        if (div_res.side.hit) begin
            n_out.hit = 1'b1;
            if (sum_x > SAT_HI) begin
                n_out.hit_x   = CW'(SAT_HI);
                n_out.clipped = 1'b1;
            end else if (sum_x < SAT_LO) begin
                n_out.hit_x   = CW'(SAT_LO);
                n_out.clipped = 1'b1;
            end else begin
                n_out.hit_x = CW'(sum_x);
            end
            if (sum_y > SAT_HI) begin
                n_out.hit_y   = CW'(SAT_HI);
                n_out.clipped = 1'b1;
            end else if (sum_y < SAT_LO) begin
                n_out.hit_y   = CW'(SAT_LO);
                n_out.clipped = 1'b1;
            end else begin
                n_out.hit_y = CW'(sum_y);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_out <= n_out;
        end
    end

    assign o_hit.valid = r_v5;
    assign o_hit.data  = r_out;

endmodule

`default_nettype wire

/* design/rsi_checker.sv */
// rsi_checker: port-level assertions for ray_segment_intersect_top,
// attached by bind; depends on rsi_pkg
`default_nettype none

module rsi_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_in_ready,
    input wire           i_out_valid,
    input wire           i_out_ready,
    input wire rsi_pkg::t_hit i_out_data
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.hit |->
            i_out_data.hit_x == '0 && i_out_data.hit_y == '0 && !i_out_data.clipped)
        else $error("miss with nonzero fields");

    // a hit on the segment always lies in range
    a_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_data.clipped)
        else $error("hit point saturated");

    // empty output register means the pipe can take a transaction
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // nothing pending right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind ray_segment_intersect_top rsi_checker u_rsi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_ray.ready),
    .i_out_valid (o_hit.valid),
    .i_out_ready (o_hit.ready),
    .i_out_data  (o_hit.data)
);

`default_nettype wire
